[src/vsfr_pkg.sv]
// Package for the value stack with remove-by-value.
// Sizes, opcode and status codes, controller states and the controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package vsfr_pkg;

  localparam int DEPTH      = 64;
  localparam int VALUE_BITS = 32;
  localparam int ADDR_BITS  = $clog2(DEPTH);
  localparam int COUNT_BITS = $clog2(DEPTH + 1);

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [ADDR_BITS-1:0]  addr_t;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_REMOVE = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_OVERFLOW  = 2'd1,
    STAT_UNDERFLOW = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_TOP_RD,
    S_TOP_WAIT,
    S_RESPOND
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic    latch_in;
    logic    do_push;
    logic    do_pop;
    logic    rd_top;
    logic    take_rd;
    logic    clear_shown;
    logic    set_status;
    status_e status;
    logic    scan_init;
    logic    scan_run;
    logic    scan_commit;
    logic    load_out;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] op;
    logic       full;
    logic       empty;
    logic       scan_done;
    logic       out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

[src/vsfr_req_if.sv]
// Request channel: valid/ready handshake with opcode and operand.
// Depends on vsfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface vsfr_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  vsfr_pkg::value_t   operand_value;

  modport source (output valid, output opcode, output operand_value, input ready);
  modport sink   (input valid, input opcode, input operand_value, output ready);
endinterface

`default_nettype wire

[src/vsfr_rsp_if.sv]
// Response channel: valid/ready handshake with top value, count, empty flag and status.
// Depends on vsfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface vsfr_rsp_if;
  logic              valid;
  logic              ready;
  vsfr_pkg::value_t  top_value;
  vsfr_pkg::count_t  entry_count;
  logic              is_empty;
  logic [1:0]        status;

  modport source (output valid, output top_value, output entry_count, output is_empty,
                  output status, input ready);
  modport sink   (input valid, input top_value, input entry_count, input is_empty,
                  input status, output ready);
endinterface

`default_nettype wire

[src/vsfr_ctrl.sv]
// Controller state machine: sequences push, pop, remove compaction and the top read.
// Depends on vsfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vsfr_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_ready,
  input  wire vsfr_pkg::dp_stat_t stat,
  output vsfr_pkg::ctrl_cmd_t     cmd
);

  vsfr_pkg::state_e state;
  vsfr_pkg::state_e state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vsfr_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      vsfr_pkg::S_IDLE: begin
        if (req_valid) state_next = vsfr_pkg::S_EXEC;
      end
      vsfr_pkg::S_EXEC: begin
        case (stat.op)
          vsfr_pkg::OP_PUSH:   state_next = vsfr_pkg::S_TOP_RD;
          vsfr_pkg::OP_POP: begin
            state_next = stat.empty ? vsfr_pkg::S_RESPOND : vsfr_pkg::S_TOP_WAIT;
          end
          vsfr_pkg::OP_REMOVE: state_next = vsfr_pkg::S_SCAN;
          default:             state_next = vsfr_pkg::S_TOP_RD;
        endcase
      end
      vsfr_pkg::S_SCAN: begin
        if (stat.scan_done) state_next = vsfr_pkg::S_TOP_RD;
      end
      vsfr_pkg::S_TOP_RD: begin
        state_next = stat.empty ? vsfr_pkg::S_RESPOND : vsfr_pkg::S_TOP_WAIT;
      end
      vsfr_pkg::S_TOP_WAIT: state_next = vsfr_pkg::S_RESPOND;
      vsfr_pkg::S_RESPOND: begin
        if (stat.out_free) state_next = vsfr_pkg::S_IDLE;
      end
      default: state_next = vsfr_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.status = vsfr_pkg::STAT_OK;
    req_ready = 1'b0;
    case (state)
      vsfr_pkg::S_IDLE: begin
        req_ready    = 1'b1;
        cmd.latch_in = req_valid;
      end
      vsfr_pkg::S_EXEC: begin
        case (stat.op)
          vsfr_pkg::OP_PUSH: begin
            if (stat.full) begin
              cmd.set_status = 1'b1;
              cmd.status     = vsfr_pkg::STAT_OVERFLOW;
            end else begin
              cmd.do_push = 1'b1;
            end
          end
          vsfr_pkg::OP_POP: begin
            if (stat.empty) begin
              cmd.set_status  = 1'b1;
              cmd.status      = vsfr_pkg::STAT_UNDERFLOW;
              cmd.clear_shown = 1'b1;
            end else begin
              cmd.do_pop = 1'b1;
            end
          end
          vsfr_pkg::OP_REMOVE: cmd.scan_init = 1'b1;
          default: ;
        endcase
      end
      vsfr_pkg::S_SCAN: begin
        if (stat.scan_done) cmd.scan_commit = 1'b1;
        else                cmd.scan_run    = 1'b1;
      end
      vsfr_pkg::S_TOP_RD: begin
        if (stat.empty) cmd.clear_shown = 1'b1;
        else            cmd.rd_top      = 1'b1;
      end
      vsfr_pkg::S_TOP_WAIT: cmd.take_rd = 1'b1;
      vsfr_pkg::S_RESPOND:  cmd.load_out = stat.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[src/vsfr_dp.sv]
// Datapath: entry memory, fill level, compaction counters and the result register.
// Depends on vsfr_pkg; driven by vsfr_ctrl commands.
`timescale 1ns / 1ps
`default_nettype none

module vsfr_dp (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire vsfr_pkg::ctrl_cmd_t cmd,
  output vsfr_pkg::dp_stat_t       stat,
  input  wire logic [1:0]          opcode,
  input  wire vsfr_pkg::value_t    operand_value,
  input  wire logic                rsp_ready,
  output logic                     rsp_valid,
  output vsfr_pkg::value_t         top_value,
  output vsfr_pkg::count_t         entry_count,
  output logic                     is_empty,
  output logic [1:0]               status
);

  vsfr_pkg::value_t mem [vsfr_pkg::DEPTH];

  logic [1:0]        op;
  vsfr_pkg::value_t  val;
  vsfr_pkg::count_t  fill;
  vsfr_pkg::count_t  rd_idx;
  vsfr_pkg::count_t  wr_idx;
  logic              pending;
  vsfr_pkg::value_t  rd_data;
  vsfr_pkg::value_t  shown;
  vsfr_pkg::status_e stat_code;

  vsfr_pkg::count_t  top_idx;
  logic              rd_more;
  logic              keep;
  logic              rd_en;
  vsfr_pkg::addr_t   rd_addr;
  logic              wr_en;
  vsfr_pkg::addr_t   wr_addr;
  vsfr_pkg::value_t  wr_data;

  assign top_idx = fill - vsfr_pkg::COUNT_BITS'(1);
  assign rd_more = rd_idx < fill;
  // entry read in the previous cycle survives the filter
  assign keep    = pending && (rd_data != val);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = top_idx[vsfr_pkg::ADDR_BITS-1:0];
    if (cmd.rd_top || cmd.do_pop) begin
      rd_en = 1'b1;
    end else if (cmd.scan_run && rd_more) begin
      rd_en   = 1'b1;
      rd_addr = rd_idx[vsfr_pkg::ADDR_BITS-1:0];
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = fill[vsfr_pkg::ADDR_BITS-1:0];
    wr_data = val;
    if (cmd.do_push) begin
      wr_en = 1'b1;
    end else if (cmd.scan_run && keep) begin
      wr_en   = 1'b1;
      wr_addr = wr_idx[vsfr_pkg::ADDR_BITS-1:0];
      wr_data = rd_data;
    end
  end

  // write address never reaches an index still to be read during compaction
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill    <= '0;
      rd_idx  <= '0;
      wr_idx  <= '0;
      pending <= 1'b0;
    end else begin
      if (cmd.do_push)     fill <= fill + vsfr_pkg::COUNT_BITS'(1);
      if (cmd.do_pop)      fill <= top_idx;
      if (cmd.scan_commit) fill <= wr_idx;
      if (cmd.scan_init) begin
        rd_idx  <= '0;
        wr_idx  <= '0;
        pending <= 1'b0;
      end else if (cmd.scan_run) begin
        pending <= rd_more;
        if (rd_more) rd_idx <= rd_idx + vsfr_pkg::COUNT_BITS'(1);
        if (keep)    wr_idx <= wr_idx + vsfr_pkg::COUNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op        <= opcode;
      val       <= operand_value;
      stat_code <= vsfr_pkg::STAT_OK;
    end
    if (cmd.set_status)  stat_code <= cmd.status;
    if (cmd.clear_shown) shown <= '0;
    if (cmd.take_rd)     shown <= rd_data;
  end

  // result register; frees up as soon as the item is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_out) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      top_value   <= shown;
      entry_count <= fill;
      is_empty    <= (fill == '0);
      status      <= stat_code;
    end
  end

  assign stat.op        = op;
  assign stat.full      = (fill == vsfr_pkg::COUNT_BITS'(vsfr_pkg::DEPTH));
  assign stat.empty     = (fill == '0);
  assign stat.scan_done = !rd_more && !pending;
  assign stat.out_free  = !rsp_valid || rsp_ready;

endmodule

`default_nettype wire

[src/value_stack_with_filter_remove_core.sv]
// Top level of the value stack with remove-by-value: controller plus datapath.
// Depends on vsfr_pkg, vsfr_req_if, vsfr_rsp_if, vsfr_ctrl and vsfr_dp.
//
//   channel | dir | payload                                       | handshake
//   req     | in  | opcode, operand_value                         | valid/ready
//   rsp     | out | top_value, entry_count, is_empty, status      | valid/ready
//
// One item at a time. Push and the unused opcode go through execute, top read and
// response; pop reads the top entry as it pops and returns it, or reports underflow
// when empty; remove runs a compaction walk through the single-read, single-write
// entry memory before the top read. The next item is taken once back in idle.
// Reset (rst, synchronous) empties the stack; memory contents are not cleared.
// A stalled rsp holds the controller in its response state until the result frees.
`timescale 1ns / 1ps
`default_nettype none

module value_stack_with_filter_remove_core (
  input  wire logic   clk,
  input  wire logic   rst,
  vsfr_req_if.sink    req,
  vsfr_rsp_if.source  rsp
);

  vsfr_pkg::ctrl_cmd_t cmd;
  vsfr_pkg::dp_stat_t  stat;

  vsfr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  vsfr_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .opcode        (req.opcode),
    .operand_value (req.operand_value),
    .rsp_ready     (rsp.ready),
    .rsp_valid     (rsp.valid),
    .top_value     (rsp.top_value),
    .entry_count   (rsp.entry_count),
    .is_empty      (rsp.is_empty),
    .status        (rsp.status)
  );

endmodule

`default_nettype wire

[src/vsfr_checker.sv]
// Port-level checks on the stack's result items, bound to the top level.
// Depends on vsfr_pkg and value_stack_with_filter_remove_core.
`timescale 1ns / 1ps
`default_nettype none

module vsfr_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             rsp_valid,
  input wire logic             rsp_ready,
  input wire vsfr_pkg::value_t top_value,
  input wire vsfr_pkg::count_t entry_count,
  input wire logic             is_empty,
  input wire logic [1:0]       status
);

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (is_empty == (entry_count == '0)))
    else $error("empty flag disagrees with entry count");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status == vsfr_pkg::STAT_OVERFLOW) |->
      (entry_count == vsfr_pkg::COUNT_BITS'(vsfr_pkg::DEPTH)))
    else $error("overflow reported on a stack that is not full");

  a_underflow_empty: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status == vsfr_pkg::STAT_UNDERFLOW) |->
      (entry_count == '0 && top_value == '0))
    else $error("underflow reported with entries or a non-zero top");

  a_empty_top_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && is_empty && status != vsfr_pkg::STAT_OK) |-> (top_value == '0))
    else $error("non-zero top on an empty stack");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=>
      (rsp_valid && $stable(top_value) && $stable(entry_count) && $stable(status)))
    else $error("stalled result changed");

endmodule

bind value_stack_with_filter_remove_core vsfr_checker u_vsfr_checker (
  .clk         (clk),
  .rst         (rst),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .top_value   (rsp.top_value),
  .entry_count (rsp.entry_count),
  .is_empty    (rsp.is_empty),
  .status      (rsp.status)
);

`default_nettype wire
